FILE: hw/rtl/pulse_charge_amplitude_macros.svh
// Assertion macros for the pulse charge/amplitude block.
// Expects signals named clock and reset in the including scope.
`ifndef PULSE_CHARGE_AMPLITUDE_MACROS_SVH
`define PULSE_CHARGE_AMPLITUDE_MACROS_SVH

// Invariant checked at every rising clock edge outside reset
`define PCA_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Implication with the consequent checked in the next cycle
`define PCA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/pca_pkg.sv
// Shared types and constants for the pulse charge/amplitude block.
// No dependencies.
`timescale 1ns / 1ps

package pca_pkg;

   localparam int SAMPLE_W  = 14;
   localparam int IDX_W     = 11;
   localparam int BSUM_W    = 24;
   localparam int WSUM_W    = 25;
   localparam int WCNT_W    = 12;
   localparam int WSTART_W  = 11;
   localparam int WEND_W    = 12;
   localparam int LOW_MAX_W = 16;
   localparam int CHARGE_W  = 34;
   localparam int AMP_W     = 22;

   localparam logic [WSTART_W-1:0] WSTART_RST = 11'd400;
   localparam logic [WEND_W-1:0]   WEND_RST   = 12'd900;

   // register index codes (paddr[2])
   localparam logic REG_WSTART = 1'b0;
   localparam logic REG_WEND   = 1'b1;

   // result queue
   localparam int DEPTH = 8;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic signed [47:0] CHARGE_MAX = 48'sd8589934591;
   localparam logic signed [47:0] CHARGE_MIN = -48'sd8589934592;
   localparam logic signed [35:0] AMP_MAX    = 36'sd4194303;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last_sample;
   } req_type;

   typedef struct packed {
      logic signed [CHARGE_W-1:0] charge;
      logic [AMP_W-1:0]           amplitude;
      logic                       window_cut_short;
   } rsp_type;

   // per-waveform values carried down the finishing pipeline
   typedef struct packed {
      logic [WCNT_W-1:0]    wcnt;
      logic [WSUM_W-1:0]    wsum;
      logic [LOW_MAX_W-1:0] low;
      logic                 cut;
   } carry_type;

endpackage

FILE: hw/rtl/pca_const_div.sv
// Two-stage divider by a constant: reciprocal multiply, then one correction step.
// Standalone; used by pulse_charge_amplitude.
`timescale 1ns / 1ps

module pca_const_div #(
   parameter int W       = 24,
   parameter int DIVISOR = 200
) (
   input  logic         clock,
   input  logic [W-1:0] x,
   output logic [W-1:0] quo,
   output logic [W-1:0] rem
);

   // floor(2^W / D): estimate is never more than one below the true quotient
   localparam logic [W:0]   RECIP = (W+1)'((64'd1 << W) / DIVISOR);
   localparam logic [W-1:0] DIV_W = W'(DIVISOR);

   logic [W-1:0]   x_ff;
   logic [W-1:0]   est_ff;
   logic [2*W:0]   prod_a;
   logic [2*W-1:0] prod_b;
   logic [W-1:0]   rem_est;
   logic [W-1:0]   quo_in;
   logic [W-1:0]   rem_in;

   assign prod_a = x * RECIP;

   always_ff @(posedge clock) begin
      x_ff   <= x;
      est_ff <= prod_a[2*W-1:W];
   end

   always_comb begin
      prod_b  = est_ff * DIV_W;
      rem_est = x_ff - prod_b[W-1:0];
      if (rem_est >= DIV_W) begin
         quo_in = est_ff + W'(1);
         rem_in = rem_est - DIV_W;
      end else begin
         quo_in = est_ff;
         rem_in = rem_est;
      end
   end

   always_ff @(posedge clock) begin
      quo <= quo_in;
      rem <= rem_in;
   end

endmodule

FILE: hw/rtl/pulse_charge_amplitude.sv
// Baseline-subtracted charge and amplitude of photomultiplier waveforms. Takes one sample
// per clock, with no gaps, while req_ready is high; once the last sample of a waveform is
// accepted, its result passes through the finishing pipeline (three constant dividers of
// two stages each). Results wait in an 8-entry queue; req_ready drops only while 8 results
// are outstanding (in the pipeline or queued) and not yet taken.
// Depends on pca_pkg, pca_const_div and pulse_charge_amplitude_macros.svh.
`timescale 1ns / 1ps
`include "pulse_charge_amplitude_macros.svh"

module pulse_charge_amplitude #(
   parameter int BASELINE_LEN = 200,
   parameter int MAX_SAMPLES  = 2048,
   parameter int SAMPLE_BITS  = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pca_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pca_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int LOW_W = SAMPLE_BITS;
   localparam logic [pca_pkg::SAMPLE_W-1:0] SMASK =
      pca_pkg::SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);
   localparam logic [pca_pkg::IDX_W-1:0] BASE_END = pca_pkg::IDX_W'(BASELINE_LEN);
   localparam logic [pca_pkg::IDX_W-1:0] IDX_LAST = pca_pkg::IDX_W'(MAX_SAMPLES - 1);
   localparam logic [31:0] BASE_C = 32'(BASELINE_LEN);
   localparam logic [pca_pkg::CNT_W-1:0] DEPTH_C = pca_pkg::CNT_W'(pca_pkg::DEPTH);

   // ---------------- configuration ----------------
   logic [pca_pkg::WSTART_W-1:0] wstart_ff, wstart_in;
   logic [pca_pkg::WEND_W-1:0]   wend_ff, wend_in;
   logic                         csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      wstart_in = wstart_ff;
      wend_in   = wend_ff;
      if (csr_wr) begin
         case (paddr[2])
            pca_pkg::REG_WSTART: wstart_in = pwdata[pca_pkg::WSTART_W-1:0];
            pca_pkg::REG_WEND:   wend_in   = pwdata[pca_pkg::WEND_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         pca_pkg::REG_WSTART: prdata = {21'b0, wstart_ff};
         pca_pkg::REG_WEND:   prdata = {20'b0, wend_ff};
         default:             prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wstart_ff <= pca_pkg::WSTART_RST;
         wend_ff   <= pca_pkg::WEND_RST;
      end else begin
         wstart_ff <= wstart_in;
         wend_ff   <= wend_in;
      end
   end

   // ---------------- per-sample accumulation ----------------
   logic [pca_pkg::IDX_W-1:0]  idx_ff, idx_in, idx_nx;
   logic [pca_pkg::BSUM_W-1:0] bsum_ff, bsum_in, bsum_nx;
   logic [pca_pkg::WSUM_W-1:0] wsum_ff, wsum_in, wsum_nx;
   logic [pca_pkg::WCNT_W-1:0] wcnt_ff, wcnt_in, wcnt_nx;
   logic [LOW_W-1:0]           low_ff, low_in, low_nx, smp_low;
   logic [pca_pkg::SAMPLE_W-1:0] smp;
   logic                       in_base, in_win, req_hs, rsp_hs, acc_last;
   logic [pca_pkg::WEND_W-1:0] seen;

   logic                       fin_vld_ff, fin_vld_in;
   logic [pca_pkg::BSUM_W-1:0] fin_bsum_ff;
   pca_pkg::carry_type         fin_carry_ff, fin_carry_in;

   assign req_hs   = req_valid && req_ready;
   assign rsp_hs   = rsp_valid && rsp_ready;
   assign acc_last = req_hs && req_data.last_sample;

   always_comb begin
      smp     = req_data.sample & SMASK;
      smp_low = LOW_W'(smp);
      in_base = idx_ff < BASE_END;
      in_win  = (idx_ff >= wstart_ff) && ({1'b0, idx_ff} < wend_ff);
      bsum_nx = in_base ? bsum_ff + pca_pkg::BSUM_W'(smp) : bsum_ff;
      wsum_nx = in_win ? wsum_ff + pca_pkg::WSUM_W'(smp) : wsum_ff;
      wcnt_nx = in_win ? wcnt_ff + pca_pkg::WCNT_W'(1) : wcnt_ff;
      low_nx  = (smp_low < low_ff) ? smp_low : low_ff;
      idx_nx  = (idx_ff < IDX_LAST) ? idx_ff + pca_pkg::IDX_W'(1) : idx_ff;
      seen    = {1'b0, idx_ff} + pca_pkg::WEND_W'(1);

      fin_carry_in.wcnt = wcnt_nx;
      fin_carry_in.wsum = wsum_nx;
      fin_carry_in.low  = pca_pkg::LOW_MAX_W'(low_nx);
      fin_carry_in.cut  = seen < wend_ff;
      fin_vld_in        = acc_last;

      idx_in  = idx_ff;
      bsum_in = bsum_ff;
      wsum_in = wsum_ff;
      wcnt_in = wcnt_ff;
      low_in  = low_ff;
      if (req_hs) begin
         if (req_data.last_sample) begin
            idx_in  = '0;
            bsum_in = '0;
            wsum_in = '0;
            wcnt_in = '0;
            low_in  = '1;
         end else begin
            idx_in  = idx_nx;
            bsum_in = bsum_nx;
            wsum_in = wsum_nx;
            wcnt_in = wcnt_nx;
            low_in  = low_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         bsum_ff    <= '0;
         wsum_ff    <= '0;
         wcnt_ff    <= '0;
         low_ff     <= '1;
         fin_vld_ff <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         bsum_ff    <= bsum_in;
         wsum_ff    <= wsum_in;
         wcnt_ff    <= wcnt_in;
         low_ff     <= low_in;
         fin_vld_ff <= fin_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_bsum_ff  <= bsum_nx;
      fin_carry_ff <= fin_carry_in;
   end

   // ---------------- finishing pipeline ----------------
   // bsum = q1*B + r1; the rounded quotients then split into an exact part and a
   // remainder part: charge = 256*wcnt*q1 + round(256*wcnt*r1/B) - 256*wsum.
   logic [pca_pkg::BSUM_W-1:0] q1, r1;
   logic [31:0]                q2, q2_rem;
   logic [19:0]                q3, q3_rem;
   logic [31:0]                x2_in;
   logic [19:0]                x3_in;
   logic [21:0]                wr_prod;

   logic               p2_vld_ff, p3_vld_ff, p4_vld_ff, p5_vld_ff, p6_vld_ff;
   pca_pkg::carry_type p2_carry_ff, p3_carry_ff, p4_carry_ff, p5_carry_ff, p6_carry_ff;
   logic [35:0]        p4_wq_ff, p5_wq_ff, p6_wq_ff;
   logic [pca_pkg::BSUM_W-1:0] p4_q1_ff, p5_q1_ff, p6_q1_ff;
   logic [31:0]        p4_x2_ff;
   logic [19:0]        p4_x3_ff;

   pca_const_div #(.W(pca_pkg::BSUM_W), .DIVISOR(BASELINE_LEN)) u_div_base (
      .clock (clock),
      .x     (fin_bsum_ff),
      .quo   (q1),
      .rem   (r1)
   );

   assign wr_prod = 22'(p3_carry_ff.wcnt) * 22'(r1[9:0]);
   assign x2_in   = {wr_prod[21:0], 9'b0} + BASE_C;
   assign x3_in   = {1'b0, r1[9:0], 9'b0} + BASE_C[19:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
         p5_vld_ff <= 1'b0;
         p6_vld_ff <= 1'b0;
      end else begin
         p2_vld_ff <= fin_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
         p5_vld_ff <= p4_vld_ff;
         p6_vld_ff <= p5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_carry_ff <= fin_carry_ff;
      p3_carry_ff <= p2_carry_ff;
      p4_carry_ff <= p3_carry_ff;
      p5_carry_ff <= p4_carry_ff;
      p6_carry_ff <= p5_carry_ff;
      p4_wq_ff    <= 36'(p3_carry_ff.wcnt) * 36'(q1);
      p5_wq_ff    <= p4_wq_ff;
      p6_wq_ff    <= p5_wq_ff;
      p4_q1_ff    <= q1;
      p5_q1_ff    <= p4_q1_ff;
      p6_q1_ff    <= p5_q1_ff;
      p4_x2_ff    <= x2_in;
      p4_x3_ff    <= x3_in;
   end

   pca_const_div #(.W(32), .DIVISOR(2 * BASELINE_LEN)) u_div_charge (
      .clock (clock),
      .x     (p4_x2_ff),
      .quo   (q2),
      .rem   (q2_rem)
   );

   pca_const_div #(.W(20), .DIVISOR(2 * BASELINE_LEN)) u_div_amp (
      .clock (clock),
      .x     (p4_x3_ff),
      .quo   (q3),
      .rem   (q3_rem)
   );

   logic signed [47:0] charge_raw;
   logic signed [35:0] amp_raw;
   pca_pkg::rsp_type   result;

   always_comb begin
      charge_raw = $signed({4'b0, p6_wq_ff, 8'b0}) + $signed({16'b0, q2})
                 - $signed({15'b0, p6_carry_ff.wsum, 8'b0});
      amp_raw    = $signed({4'b0, p6_q1_ff, 8'b0}) + $signed({16'b0, q3})
                 - $signed({12'b0, p6_carry_ff.low, 8'b0});
      if (charge_raw > pca_pkg::CHARGE_MAX) begin
         result.charge = pca_pkg::CHARGE_W'(pca_pkg::CHARGE_MAX);
      end else if (charge_raw < pca_pkg::CHARGE_MIN) begin
         result.charge = pca_pkg::CHARGE_W'(pca_pkg::CHARGE_MIN);
      end else begin
         result.charge = charge_raw[pca_pkg::CHARGE_W-1:0];
      end
      if (amp_raw < 36'sd0) begin
         result.amplitude = '0;
      end else if (amp_raw > pca_pkg::AMP_MAX) begin
         result.amplitude = '1;
      end else begin
         result.amplitude = amp_raw[pca_pkg::AMP_W-1:0];
      end
      result.window_cut_short = p6_carry_ff.cut;
   end

   // ---------------- result queue ----------------
   // owed counts results promised to the consumer: in the pipeline or queued
   pca_pkg::rsp_type           queue_ff [pca_pkg::DEPTH];
   logic [pca_pkg::PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [pca_pkg::CNT_W-1:0]  cnt_ff, cnt_in, owed_ff, owed_in;

   assign req_ready = owed_ff < DEPTH_C;
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = p6_vld_ff ? wr_ptr_ff + pca_pkg::PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = rsp_hs ? rd_ptr_ff + pca_pkg::PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      owed_in   = owed_ff;
      case ({p6_vld_ff, rsp_hs})
         2'b10:   cnt_in = cnt_ff + pca_pkg::CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - pca_pkg::CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
      case ({acc_last, rsp_hs})
         2'b10:   owed_in = owed_ff + pca_pkg::CNT_W'(1);
         2'b01:   owed_in = owed_ff - pca_pkg::CNT_W'(1);
         default: owed_in = owed_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         owed_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         owed_ff   <= owed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p6_vld_ff) begin
         queue_ff[wr_ptr_ff] <= result;
      end
   end

   // ---------------- checks ----------------
   `PCA_ASSERT_ALWAYS(a_queue_room, !p6_vld_ff || (cnt_ff < DEPTH_C), "result queue overflow")
   `PCA_ASSERT_ALWAYS(a_owed_covers, (cnt_ff <= owed_ff) && (owed_ff <= DEPTH_C), "owed count off")
   `PCA_ASSERT_NEXT(a_last_enters, acc_last, fin_vld_ff, "last sample lost before pipeline")

endmodule

FILE: tb/pulse_charge_amplitude_checker.sv
// Scoreboard for pulse_charge_amplitude: follows the CSR, request and result ports,
// predicts each waveform's charge/amplitude result and compares it with rsp_data.
// Depends on pca_pkg.
`timescale 1ns / 1ps

module pulse_charge_amplitude_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  pca_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  pca_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   input  logic             pready,
   output int               failures,
   output int               pending,
   output int               checked
);

   localparam int BASELINE_LEN = 200;
   localparam int LAST_INDEX   = 2047;   // index saturates at MAX_SAMPLES-1
   localparam int REPORT_LIMIT = 10;

   logic [pca_pkg::WSTART_W-1:0] win_start;
   logic [pca_pkg::WEND_W-1:0]   win_end;
   logic [pca_pkg::IDX_W-1:0]    sample_idx;
   logic [pca_pkg::BSUM_W-1:0]   base_sum;
   logic [pca_pkg::WSUM_W-1:0]   win_sum;
   logic [pca_pkg::WCNT_W-1:0]   win_cnt;
   logic [pca_pkg::SAMPLE_W-1:0] low_sample;

   pca_pkg::rsp_type predicted_pulses[$];
   int               fail_cnt  = 0;
   int               match_cnt = 0;

   // num/den rounded half up, den > 0
   function automatic longint round_half_up(input longint num, input longint den);
      longint n;
      longint d;
      n = 2 * num + den;
      d = 2 * den;
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   task automatic clear_waveform();
      sample_idx = '0;
      base_sum   = '0;
      win_sum    = '0;
      win_cnt    = '0;
      low_sample = '1;
   endtask

   task automatic take_sample(input pca_pkg::req_type r);
      logic [pca_pkg::SAMPLE_W-1:0] s;
      int                           seen;
      longint                       charge_q8;
      longint                       base_q8;
      longint                       amp_q8;
      pca_pkg::rsp_type             pulse;
      s = r.sample;
      if (sample_idx < BASELINE_LEN) base_sum = base_sum + s;
      if (sample_idx >= win_start && sample_idx < win_end) begin
         win_sum = win_sum + s;
         win_cnt = win_cnt + 1'b1;
      end
      if (s < low_sample) low_sample = s;
      seen = int'(sample_idx) + 1;
      if (sample_idx != LAST_INDEX) sample_idx = sample_idx + 1'b1;
      if (r.last_sample) begin
         // short baselines still divide by the full length
         charge_q8 = round_half_up(longint'(win_cnt) * longint'(base_sum) * 256
                                   - longint'(win_sum) * 256 * BASELINE_LEN, BASELINE_LEN);
         if (charge_q8 > pca_pkg::CHARGE_MAX) charge_q8 = pca_pkg::CHARGE_MAX;
         if (charge_q8 < pca_pkg::CHARGE_MIN) charge_q8 = pca_pkg::CHARGE_MIN;
         base_q8 = round_half_up(longint'(base_sum) * 256, BASELINE_LEN);
         amp_q8  = base_q8 - longint'(low_sample) * 256;
         if (amp_q8 < 0) amp_q8 = 0;
         if (amp_q8 > pca_pkg::AMP_MAX) amp_q8 = pca_pkg::AMP_MAX;
         pulse.charge           = charge_q8[pca_pkg::CHARGE_W-1:0];
         pulse.amplitude        = amp_q8[pca_pkg::AMP_W-1:0];
         pulse.window_cut_short = (seen < win_end);
         predicted_pulses.insert(predicted_pulses.size(), pulse);
         clear_waveform();
      end
   endtask

   always @(posedge clock) begin
      pca_pkg::rsp_type want;
      if (reset) begin
         win_start = pca_pkg::WSTART_RST;
         win_end   = pca_pkg::WEND_RST;
         clear_waveform();
         predicted_pulses.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == pca_pkg::REG_WSTART) win_start = pwdata[pca_pkg::WSTART_W-1:0];
            else win_end = pwdata[pca_pkg::WEND_W-1:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_pulses.size() == 0) begin
               fail_cnt++;
               if (fail_cnt <= REPORT_LIMIT)
                  $display("%0t: unexpected result: charge %0d amp %0d cut %0b",
                           $time, rsp_data.charge, rsp_data.amplitude,
                           rsp_data.window_cut_short);
            end else begin
               want = predicted_pulses.pop_front();
               if (rsp_data.charge !== want.charge || rsp_data.amplitude !== want.amplitude ||
                   rsp_data.window_cut_short !== want.window_cut_short) begin
                  fail_cnt++;
                  if (fail_cnt <= REPORT_LIMIT)
                     $display("%0t: result %0d exp/got: charge %0d/%0d amp %0d/%0d cut %0b/%0b",
                              $time, match_cnt, want.charge, rsp_data.charge,
                              want.amplitude, rsp_data.amplitude,
                              want.window_cut_short, rsp_data.window_cut_short);
               end
               match_cnt++;
            end
         end
         if (req_valid && req_ready) take_sample(req_data);
      end
      failures <= fail_cnt;
      pending  <= predicted_pulses.size();
      checked  <= match_cnt;
   end

endmodule

FILE: tb/pulse_charge_amplitude_tb.sv
// Top of the pulse_charge_amplitude testbench: clock, reset, CSR writes and sample
// stimulus; checking is done by pulse_charge_amplitude_checker.
// Depends on pca_pkg, pulse_charge_amplitude and pulse_charge_amplitude_checker.
`timescale 1ns / 1ps

module pulse_charge_amplitude_tb;

   localparam int FULL_SCALE = 16383;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pca_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   pca_pkg::rsp_type rsp_data;
   logic             psel      = 1'b0;
   logic             penable   = 1'b0;
   logic             pwrite    = 1'b0;
   logic [2:0]       paddr     = '0;
   logic [31:0]      pwdata    = '0;
   logic [31:0]      prdata;
   logic             pready;

   int failures;
   int pending;
   int checked;

   bit steady         = 1'b0;   // no idling on either side while set
   int samples_sent   = 0;
   int waveforms_sent = 0;
   int settings_used  = 0;

   pulse_charge_amplitude uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   pulse_charge_amplitude_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .failures(failures), .pending(pending), .checked(checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 35);
   end

   task automatic send_sample(input logic [pca_pkg::SAMPLE_W-1:0] s, input logic last);
      while (!steady && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{sample: s, last_sample: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      samples_sent++;
      if (last) waveforms_sent++;
   endtask

   // drain all results, then give the finishing pipeline time to go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(input logic index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_window(input int first, input int past_end);
      settle();
      csr_write(pca_pkg::REG_WSTART, first);
      csr_write(pca_pkg::REG_WEND, past_end);
      settings_used++;
   endtask

   task automatic send_waveform(input int len);
      int style;
      int level;
      int depth;
      int dip_at;
      int dip_len;
      int v;
      style   = $urandom_range(3);
      level   = $urandom_range(200, FULL_SCALE);
      depth   = $urandom_range(level);
      dip_at  = $urandom_range(len);
      dip_len = $urandom_range(1, 40);
      for (int k = 0; k < len; k++) begin
         case (style)
            0: v = $urandom_range(FULL_SCALE);
            1: v = $urandom_range(1) ? FULL_SCALE - $urandom_range(2) : $urandom_range(2);
            default: begin
               // flat baseline with a negative-going pulse
               v = level + $urandom_range(7);
               v = v - 3;
               if (k >= dip_at && k < dip_at + dip_len) v = level - depth + $urandom_range(15);
            end
         endcase
         if (v > FULL_SCALE) v = FULL_SCALE;
         if (v < 0) v = 0;
         send_sample(v[pca_pkg::SAMPLE_W-1:0], k == len - 1);
      end
   endtask

   initial begin
      int random_start;
      int random_waves;
      int pick;
      int first;
      int past_end;
      int len;
      int waves;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset window (400..900): single-sample waveforms, short baseline
      send_sample(14'h3fff, 1'b1);
      send_sample(14'h0000, 1'b1);
      set_window(0, 4);
      send_sample(14'h3fff, 1'b0);
      send_sample(14'h0000, 1'b0);
      send_sample(14'h1fff, 1'b0);
      send_sample(14'h0001, 1'b1);
      // end before start: empty window
      set_window(5, 3);
      send_sample(14'd100, 1'b0);
      send_sample(14'd200, 1'b0);
      send_sample(14'd300, 1'b1);
      // window lies beyond the waveform
      set_window(2047, 2048);
      send_sample(14'd9, 1'b0);
      send_sample(14'd10, 1'b1);
      set_window(1, 2);
      send_sample(14'h0000, 1'b0);
      send_sample(14'h3fff, 1'b0);
      send_sample(14'h3fff, 1'b1);

      // full-scale baseline then zeros over the window: large positive charge, cut short
      set_window(200, 2048);
      for (int k = 0; k < 300; k++) send_sample(k < 200 ? 14'h3fff : 14'h0000, k == 299);

      random_start = samples_sent;
      random_waves = 0;
      while (samples_sent < 1350 || random_waves < 20) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            first    = $urandom_range(40);
            past_end = $urandom_range(80);
         end else if (pick < 75) begin
            // window near the end of the baseline
            first    = $urandom_range(150, 250);
            past_end = first + $urandom_range(60);
         end else begin
            case ($urandom_range(7))
               0: begin first = 0;    past_end = 0;    end
               1: begin first = 0;    past_end = 2048; end
               2: begin first = 2047; past_end = 2048; end
               3: begin first = 2047; past_end = 0;    end
               4: begin first = 400;  past_end = 900;  end
               5: begin first = 1023; past_end = 2047; end
               6: begin first = 1024; past_end = 2048; end
               default: begin first = 0; past_end = 1; end
            endcase
         end
         set_window(first, past_end);
         waves = $urandom_range(2, 6);
         for (int w = 0; w < waves; w++) begin
            steady = (samples_sent - random_start >= 300) && (samples_sent - random_start < 650);
            pick = $urandom_range(99);
            if (pick < 70) len = $urandom_range(1, 24);
            else if (pick < 90) len = $urandom_range(25, 100);
            else len = $urandom_range(180, 230);
            send_waveform(len);
            random_waves++;
         end
      end
      steady = 1'b0;

      settle();
      repeat (20) @(posedge clock);
      $display("Streamed %0d samples in %0d waveforms across %0d window settings.",
               samples_sent, waveforms_sent, settings_used);
      $display("Compared %0d results, %0d failures.", checked, failures);
      if (failures == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d results outstanding.", pending);
      $display("== FAIL ==");
      $finish;
   end

endmodule
